// File: hw/rtl/skip_copy_delta_frame_decoder_core_macros.svh
// Assertion macros shared by the delta frame decoder RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SKIP_COPY_DELTA_FRAME_DECODER_CORE_MACROS_SVH
`define SKIP_COPY_DELTA_FRAME_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/scdf_pkg.sv
// Shared types, codes and constants of the delta frame decoder.
// No dependencies; the front, queue, back and top refer to it by scoped names.
package scdf_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0]  PAL_LIMIT       = 9'(PALETTE_ENTRIES);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  TOP_ROW_OFFSET_RESET = 8'd30;
    localparam logic [12:0] LINE_STRIDE_RESET    = 13'd1280;
    localparam logic [7:0]  ROWS_PER_FRAME_RESET = 8'd180;

    localparam logic [1:0]  ROW_END_MARK = 2'b11;
    localparam logic [8:0]  ROW_MAX      = 9'd511;
    localparam logic [12:0] COL_MAX      = 13'd8191;

    typedef enum logic [1:0] {
        MODE_CONTROL = 2'd0,
        MODE_PIXEL   = 2'd1,
        MODE_PALETTE = 2'd2,
        MODE_START   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_TOP_ROW_OFFSET = 2'd0,
        CFG_LINE_STRIDE    = 2'd1,
        CFG_ROWS_PER_FRAME = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_PAL_WRITE = 2'd1,
        CMD_PIXEL     = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic [7:0]  palette_index;
        logic [15:0] palette_color;
    } scdf_in_t;

    typedef struct packed {
        logic        write_valid;
        logic [21:0] write_address;
        logic [15:0] pixel_color;
        logic        want_pixel;
        logic        frame_done;
        logic        format_error;
    } scdf_out_t;

    typedef struct packed {
        logic        write_en;
        logic [1:0]  index;
        logic [12:0] data;
    } scdf_cfg_wr_t;

    // One classified beat, handed from the front to the back.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        write_valid;
        logic        want_pixel;
        logic        frame_done;
        logic        format_error;
        logic [9:0]  row_sum;
        logic [12:0] column;
        logic [7:0]  index;
        logic [15:0] color;
    } scdf_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } scdf_q_status_t;

endpackage

// File: hw/rtl/scdf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module scdf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/scdf_front.sv
// Front of the delta frame decoder: configuration registers, row and column
// tracking, and classification of every accepted beat. Uses scdf_pkg.
`include "skip_copy_delta_frame_decoder_core_macros.svh"

module scdf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scdf_pkg::scdf_cfg_wr_t cfg_wr,
    input  scdf_pkg::scdf_in_t    item,
    input  logic                  accept,
    output scdf_pkg::scdf_cmd_t   cmd,
    output logic [12:0]           stride
);

    logic [7:0]  top_offset_reg, top_offset_next;
    logic [12:0] stride_reg, stride_next;
    logic [7:0]  rows_reg, rows_next;

    logic [8:0]  row_reg, row_next;
    logic [12:0] column_reg, column_next;
    logic        skip_reg, skip_next;
    logic [8:0]  left_reg, left_next;
    logic        active_reg, active_next;

    logic [9:0]  row_end_sum;
    logic [8:0]  row_end_sat;
    logic [13:0] skip_sum;
    logic [13:0] pix_sum;
    logic [12:0] pix_col_sat;

    always_comb
    begin
        top_offset_next = top_offset_reg;
        stride_next     = stride_reg;
        rows_next       = rows_reg;
        if (cfg_wr.write_en)
        begin
            case (cfg_wr.index)
                scdf_pkg::CFG_TOP_ROW_OFFSET: top_offset_next = cfg_wr.data[7:0];
                scdf_pkg::CFG_LINE_STRIDE:    stride_next     = cfg_wr.data;
                scdf_pkg::CFG_ROWS_PER_FRAME: rows_next       = cfg_wr.data[7:0];
                default: ;
            endcase
        end
    end

    assign row_end_sum = {1'b0, row_reg} + 10'd1 + {4'b0, item.byte_value[5:0]};
    assign row_end_sat = row_end_sum[9] ? scdf_pkg::ROW_MAX : row_end_sum[8:0];
    assign skip_sum    = {1'b0, column_reg} + {4'b0, item.byte_value, 2'b00};
    assign pix_sum     = {1'b0, column_reg} + 14'd2;
    assign pix_col_sat = pix_sum[13] ? scdf_pkg::COL_MAX : pix_sum[12:0];

    always_comb
    begin
        row_next    = row_reg;
        column_next = column_reg;
        skip_next   = skip_reg;
        left_next   = left_reg;
        active_next = active_reg;
        cmd         = '0;
        cmd.kind    = scdf_pkg::CMD_NONE;
        case (item.mode)
            scdf_pkg::MODE_START:
            begin
                row_next    = '0;
                column_next = '0;
                skip_next   = 1'b1;
                left_next   = '0;
                active_next = 1'b1;
            end
            scdf_pkg::MODE_PALETTE:
            begin
                cmd.kind  = scdf_pkg::CMD_PAL_WRITE;
                cmd.index = item.palette_index;
                cmd.color = item.palette_color;
            end
            scdf_pkg::MODE_CONTROL:
            begin
                if (!active_reg || left_reg != 9'd0)
                begin
                    cmd.format_error = 1'b1;
                end
                else if (item.byte_value[7:6] == scdf_pkg::ROW_END_MARK)
                begin
                    row_next    = row_end_sat;
                    column_next = '0;
                    skip_next   = 1'b1;
                    if (row_end_sat >= {1'b0, rows_reg})
                    begin
                        cmd.frame_done = 1'b1;
                        active_next    = 1'b0;
                    end
                end
                else if (skip_reg)
                begin
                    column_next = skip_sum[13] ? scdf_pkg::COL_MAX : skip_sum[12:0];
                    skip_next   = 1'b0;
                end
                else
                begin
                    left_next = {item.byte_value, 1'b0};
                    skip_next = 1'b1;
                end
            end
            scdf_pkg::MODE_PIXEL:
            begin
                if (!active_reg || left_reg == 9'd0)
                begin
                    cmd.format_error = 1'b1;
                end
                else
                begin
                    if (pix_sum > {1'b0, stride_reg})
                    begin
                        cmd.format_error = 1'b1;
                    end
                    else
                    begin
                        cmd.kind        = scdf_pkg::CMD_PIXEL;
                        cmd.write_valid = 1'b1;
                        cmd.row_sum     = {1'b0, row_reg} + {2'b0, top_offset_reg};
                        cmd.column      = column_reg;
                        cmd.index       = item.byte_value;
                    end
                    column_next = pix_col_sat;
                    left_next   = left_reg - 9'd1;
                end
            end
            default: ;
        endcase
        cmd.want_pixel = (left_next != 9'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_offset_reg <= scdf_pkg::TOP_ROW_OFFSET_RESET;
            stride_reg     <= scdf_pkg::LINE_STRIDE_RESET;
            rows_reg       <= scdf_pkg::ROWS_PER_FRAME_RESET;
            row_reg        <= '0;
            column_reg     <= '0;
            skip_reg       <= 1'b1;
            left_reg       <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            top_offset_reg <= top_offset_next;
            stride_reg     <= stride_next;
            rows_reg       <= rows_next;
            if (accept)
            begin
                row_reg    <= row_next;
                column_reg <= column_next;
                skip_reg   <= skip_next;
                left_reg   <= left_next;
                active_reg <= active_next;
            end
        end
    end

    assign stride = stride_reg;

    // Pixels can only be owed inside an active frame.
    `SCDF_ASSERT_SAME(a_left_needs_frame, left_reg != 9'd0, active_reg,
        "pixels expected while no frame is active")

endmodule

// File: hw/rtl/scdf_queue.sv
// Short register queue between the decoder front and back.
// Uses scdf_pkg for the command type and depth constants.
`include "skip_copy_delta_frame_decoder_core_macros.svh"

module scdf_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  scdf_pkg::scdf_cmd_t      push_cmd,
    input  logic                     pop,
    output scdf_pkg::scdf_cmd_t      head,
    output scdf_pkg::scdf_q_status_t status
);

    scdf_pkg::scdf_cmd_t                 entries_reg [scdf_pkg::QUEUE_DEPTH];
    logic [scdf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [scdf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [scdf_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;

    localparam logic [scdf_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        scdf_pkg::QUEUE_PTR_W'(scdf_pkg::QUEUE_DEPTH - 1);
    localparam logic [scdf_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        scdf_pkg::QUEUE_CNT_W'(scdf_pkg::QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);

    `SCDF_ASSERT_SAME(a_no_overflow, push && !pop, count_reg != FULL_COUNT,
        "queue written while full")
    `SCDF_ASSERT_SAME(a_no_underflow, pop, count_reg != '0,
        "queue read while empty")

endmodule

// File: hw/rtl/scdf_back.sv
// Back of the delta frame decoder: palette memory, address multiply and the
// result register. Uses scdf_pkg and scdf_ram.
`include "skip_copy_delta_frame_decoder_core_macros.svh"

module scdf_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  scdf_pkg::scdf_cmd_t      head,
    input  scdf_pkg::scdf_q_status_t q_status,
    input  logic [12:0]              stride,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output scdf_pkg::scdf_out_t      result
);

    logic                 s1_valid_reg, s1_valid_next;
    scdf_pkg::scdf_cmd_t  s1_cmd_reg;
    logic [22:0]          s1_product_reg;
    logic                 s1_oob_reg;

    logic                 result_valid_reg, result_valid_next;
    scdf_pkg::scdf_out_t  result_reg;

    logic                 advance;
    logic                 ram_we;
    logic                 ram_re;
    logic                 head_in_range;
    logic [15:0]          ram_rdata;
    logic [22:0]          addr_sum;

    assign advance = s1_valid_reg && (!result_valid_reg || result_ready);
    assign pop     = !q_status.empty && (!s1_valid_reg || advance);

    assign head_in_range = ({1'b0, head.index} < scdf_pkg::PAL_LIMIT);
    assign ram_we = pop && (head.kind == scdf_pkg::CMD_PAL_WRITE) && head_in_range;
    assign ram_re = pop && (head.kind == scdf_pkg::CMD_PIXEL);

    scdf_ram #(
        .WIDTH (16),
        .DEPTH (scdf_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.index[scdf_pkg::PAL_ADDR_W-1:0]),
        .wdata (head.color),
        .re    (ram_re),
        .raddr (head.index[scdf_pkg::PAL_ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Stage one: row base multiply while the palette read is in flight.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg     <= head;
            s1_product_reg <= {13'b0, head.row_sum} * {10'b0, stride};
            s1_oob_reg     <= !head_in_range;
        end
    end

    assign addr_sum = s1_product_reg + {10'b0, s1_cmd_reg.column};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.write_valid   <= s1_cmd_reg.write_valid;
            result_reg.write_address <= s1_cmd_reg.write_valid ? addr_sum[21:0] : '0;
            result_reg.pixel_color   <= (s1_cmd_reg.write_valid && !s1_oob_reg) ?
                                        ram_rdata : '0;
            result_reg.want_pixel    <= s1_cmd_reg.want_pixel;
            result_reg.frame_done    <= s1_cmd_reg.frame_done;
            result_reg.format_error  <= s1_cmd_reg.format_error;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SCDF_ASSERT_SAME(a_idle_write_zero, result_valid_reg && !result_reg.write_valid,
        result_reg.write_address == '0 && result_reg.pixel_color == '0,
        "address or colour set on a beat without a write")
    `SCDF_ASSERT_SAME(a_one_ram_op, ram_we, !ram_re,
        "palette written and read in the same cycle")

endmodule

// File: hw/rtl/skip_copy_delta_frame_decoder_core.sv
// Top level of the skip/copy delta frame decoder.
// Uses scdf_pkg, scdf_front, scdf_queue, scdf_back and scdf_ram.
//
//   Channel   Handshake                   Payload
//   -------   -------------------------   ---------------------------------
//   item      item_valid / item_ready     scdf_pkg::scdf_in_t, one tagged byte
//   result    result_valid / result_ready scdf_pkg::scdf_out_t, one per item
//   config    cfg_write_en                cfg_index, cfg_data (13 bits)
//
// One beat is accepted per cycle while the queue is not full; its result passes
// in turn through the queue entry, multiply and palette read, and result register.
// Reset clears control state only; palette entries hold nothing until written.
// A two-entry queue sits between the classifier and the back, so item_ready
// drops only once the queue is full; a stalled result holds in its register.

module skip_copy_delta_frame_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  scdf_pkg::scdf_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output scdf_pkg::scdf_out_t result
);

    scdf_pkg::scdf_cfg_wr_t   cfg_wr;
    scdf_pkg::scdf_cmd_t      front_cmd;
    scdf_pkg::scdf_cmd_t      queue_head;
    scdf_pkg::scdf_q_status_t queue_status;
    logic [12:0]              stride;
    logic                     accept;
    logic                     pop;

    assign cfg_wr.write_en = cfg_write_en;
    assign cfg_wr.index    = cfg_index;
    assign cfg_wr.data     = cfg_data;

    // The front only looks at the queue's fill level, never at the result side.
    assign item_ready = !queue_status.full;
    assign accept     = item_valid && item_ready;

    // Classifies each beat and keeps row, column and copy-run state.
    scdf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .item   (item),
        .accept (accept),
        .cmd    (front_cmd),
        .stride (stride)
    );

    // Palette writes travel through the queue with the pixels, so every lookup
    // sees exactly the palette writes that came before it.
    scdf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (queue_head),
        .status   (queue_status)
    );

    // Performs palette access and address arithmetic, then drives results.
    scdf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (queue_head),
        .q_status     (queue_status),
        .stride       (stride),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
